// ===== src/mms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types and constants for the matrix mirror symmetry and sum block.
// ----------------------------------------------------------------------------
package mms_pkg;

   // Fixed field widths.
   localparam int SUM_W  = 26;
   localparam int SIZE_W = 6;
   localparam int CODE_W = 2;

   // Symmetry codes: bit 1 is the horizontal mirror, bit 0 the vertical one.
   localparam logic [CODE_W-1:0] SYM_00 = 2'd0;
   localparam logic [CODE_W-1:0] SYM_0V = 2'd1;
   localparam logic [CODE_W-1:0] SYM_H0 = 2'd2;
   localparam logic [CODE_W-1:0] SYM_HV = 2'd3;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_CHECK
   } mms_state_type;

   // Control for the element being checked, sequencer to accumulator.
   typedef struct packed {
      logic fire;     // element is in its check cycle
      logic restart;  // drop progress before this element
      logic chk_h;    // horizontal mirror has already arrived
      logic chk_v;    // vertical mirror has already arrived
      logic last;     // element closes the matrix
   } mms_item_type;

endpackage

// ===== src/matrix_mirror_symmetry_and_sum_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_mirror_symmetry_and_sum_top
// Checks each square matrix for mirror symmetry and sums its elements.
// ----------------------------------------------------------------------------
// Flow: one element at a time, set by the store's read, compare and write-back
// sequence (mirror reads on accept, write-back in the check cycle); a closing
// element waits while a result is pending. The result beat passes the element
// in-flight and output registers and is held until taken. Reset: synchronous;
// size returns to 1; position, sum and result valid clear; symmetry flags set.
// The element store is not cleared; only entries of the current matrix are read.
module matrix_mirror_symmetry_and_sum_top #(
   parameter int MAX_SIDE   = 32,
   parameter int DATA_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [DATA_WIDTH-1:0]           req_element_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mms_pkg::SUM_W-1:0]       rsp_element_sum,
   output logic [mms_pkg::CODE_W-1:0]      rsp_symmetry_code,
   input  logic                            csr_write_enable,
   input  logic [mms_pkg::SIZE_W-1:0]      csr_write_data
);

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(DEPTH) : 1;

   logic [ADDR_W-1:0]     rd_addr_a;
   logic [ADDR_W-1:0]     rd_addr_b;
   logic [ADDR_W-1:0]     wr_addr;
   logic                  wr_en;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [DATA_WIDTH-1:0] rd_data_a;
   logic [DATA_WIDTH-1:0] rd_data_b;
   logic                  rsp_busy;
   mms_pkg::mms_item_type item;

   // A result beat that is not taken this cycle still occupies the slot.
   assign rsp_busy = rsp_valid && !rsp_ready;

   // Sequencer: positions, mirror addresses and accept control.
   mms_seq #(
      .MAX_SIDE   (MAX_SIDE),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_element_value (req_element_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_busy          (rsp_busy),
      .rd_addr_a         (rd_addr_a),
      .rd_addr_b         (rd_addr_b),
      .wr_en             (wr_en),
      .wr_addr           (wr_addr),
      .wr_data           (wr_data),
      .item              (item)
   );

   // Element store.
   mms_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // Compare, sum and result register.
   mms_acc #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_acc (
      .clock             (clock),
      .reset             (reset),
      .clear             (csr_write_enable),
      .item              (item),
      .value             (wr_data),
      .rd_data_a         (rd_data_a),
      .rd_data_b         (rd_data_b),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_element_sum   (rsp_element_sum),
      .rsp_symmetry_code (rsp_symmetry_code)
   );

endmodule

// ===== src/mms_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_ram
// Generic synchronous RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]                         rd_data_a,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]                         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read ports.
   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== src/mms_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_seq
// Position tracking, mirror address generation and accept control.
// ----------------------------------------------------------------------------
module mms_seq #(
   parameter int MAX_SIDE   = 32,
   parameter int DATA_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [DATA_WIDTH-1:0]           req_element_value,
   input  logic                            csr_write_enable,
   input  logic [mms_pkg::SIZE_W-1:0]      csr_write_data,
   input  logic                            rsp_busy,
   output logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1)-1:0] rd_addr_a,
   output logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1)-1:0] rd_addr_b,
   output logic                            wr_en,
   output logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1)-1:0] wr_addr,
   output logic [DATA_WIDTH-1:0]           wr_data,
   output mms_pkg::mms_item_type           item
);

   localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int ADDR_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CMP_W  = (SIDE_W > mms_pkg::SIZE_W) ? SIDE_W : mms_pkg::SIZE_W;

   mms_pkg::mms_state_type state_ff, state_in;
   mms_pkg::mms_item_type  item_ff, item_in;

   logic [mms_pkg::SIZE_W-1:0] size_ff;
   logic [IDX_W-1:0]           row_ff, row_in;
   logic [IDX_W-1:0]           col_ff, col_in;
   logic [DATA_WIDTH-1:0]      value_ff;
   logic [ADDR_W-1:0]          addr_ff;

   logic [CMP_W-1:0] size_ext;
   logic [CMP_W-1:0] side;
   logic [CMP_W-1:0] side_m1;
   logic [CMP_W-1:0] row_ext;
   logic [CMP_W-1:0] col_ext;
   logic             guard;
   logic [IDX_W-1:0] row_eff;
   logic [IDX_W-1:0] col_eff;
   logic [CMP_W-1:0] row_eff_ext;
   logic [CMP_W-1:0] col_eff_ext;
   logic [IDX_W-1:0] mirror_row;
   logic [IDX_W-1:0] mirror_col;
   logic             row_end;
   logic             col_end;
   logic             is_last;
   logic             accept;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      addr_of = ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_SIDE) + ADDR_W'(c));
   endfunction

   // Effective side length: zero counts as one, and it is capped at MAX_SIDE.
   always_comb begin
      size_ext = CMP_W'(size_ff);
      if (size_ext == '0) begin
         side = CMP_W'(1);
      end else if (size_ext > CMP_W'(MAX_SIDE)) begin
         side = CMP_W'(MAX_SIDE);
      end else begin
         side = size_ext;
      end
      side_m1 = side - CMP_W'(1);
   end

   // Position of the waiting element, restarted if left over from a larger size.
   always_comb begin
      row_ext     = CMP_W'(row_ff);
      col_ext     = CMP_W'(col_ff);
      guard       = (row_ext >= side) || (col_ext >= side);
      row_eff     = guard ? '0 : row_ff;
      col_eff     = guard ? '0 : col_ff;
      row_eff_ext = CMP_W'(row_eff);
      col_eff_ext = CMP_W'(col_eff);
      row_end     = (row_eff_ext == side_m1);
      col_end     = (col_eff_ext == side_m1);
      is_last     = row_end && col_end;
      mirror_row  = IDX_W'(side_m1 - row_eff_ext);
      mirror_col  = IDX_W'(side_m1 - col_eff_ext);
   end

   // Mirror reads are issued on the accepting edge.
   assign rd_addr_a = addr_of(mirror_row, col_eff);
   assign rd_addr_b = addr_of(row_eff, mirror_col);

   // The element is written back in its check cycle.
   assign wr_addr = addr_ff;
   assign wr_data = value_ff;
   assign item    = item_ff;

   // Control for the element that is accepted now.
   always_comb begin
      item_in.fire    = accept;
      item_in.restart = guard;
      item_in.chk_h   = {1'b0, side} <= {row_eff_ext, 1'b0};
      item_in.chk_v   = {1'b0, side} <= {col_eff_ext, 1'b0};
      item_in.last    = is_last;
   end

   // Next position in row-major order.
   always_comb begin
      row_in = row_eff;
      col_in = col_eff;
      if (is_last) begin
         row_in = '0;
         col_in = '0;
      end else if (col_end) begin
         row_in = row_eff + IDX_W'(1);
         col_in = '0;
      end else begin
         col_in = col_eff + IDX_W'(1);
      end
   end

   // Next state and outputs. A closing element waits until the result slot frees.
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      wr_en     = 1'b0;
      unique case (state_ff)
         mms_pkg::ST_IDLE: begin
            req_ready = !rsp_busy || !is_last;
            if (req_valid && req_ready) begin
               state_in = mms_pkg::ST_CHECK;
            end
         end
         mms_pkg::ST_CHECK: begin
            wr_en    = 1'b1;
            state_in = mms_pkg::ST_IDLE;
         end
         default: begin
            state_in = mms_pkg::ST_IDLE;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Size register and position counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= mms_pkg::SIZE_W'(1);
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            size_ff <= csr_write_data;
            row_ff  <= '0;
            col_ff  <= '0;
         end else if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   // Element in flight: only the fire flag is reset, the payload is loaded on accept.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.fire <= 1'b0;
      end else begin
         item_ff.fire <= item_in.fire;
      end
      if (accept) begin
         value_ff        <= req_element_value;
         addr_ff         <= addr_of(row_eff, col_eff);
         item_ff.restart <= item_in.restart;
         item_ff.chk_h   <= item_in.chk_h;
         item_ff.chk_v   <= item_in.chk_v;
         item_ff.last    <= item_in.last;
      end
   end

   // One element at a time: no accept in the check cycle.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("mms_seq: element accepted during its predecessor's check cycle");

   // The check cycle writes the store and marks the element as firing.
   a_check_writes: assert property (@(posedge clock) disable iff (reset)
      accept |=> (wr_en && item.fire))
      else $error("mms_seq: accepted element was not written back");

   // A size write restarts at the first element.
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (row_ff == '0 && col_ff == '0))
      else $error("mms_seq: size write did not restart the position");

endmodule

// ===== src/mms_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mms_acc
// Mirror compare, running sum, symmetry flags and the result register.
// ----------------------------------------------------------------------------
module mms_acc #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clear,
   input  mms_pkg::mms_item_type           item,
   input  logic [DATA_WIDTH-1:0]           value,
   input  logic [DATA_WIDTH-1:0]           rd_data_a,
   input  logic [DATA_WIDTH-1:0]           rd_data_b,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [mms_pkg::SUM_W-1:0]       rsp_element_sum,
   output logic [mms_pkg::CODE_W-1:0]      rsp_symmetry_code
);

   logic [mms_pkg::SUM_W-1:0]  sum_ff;
   logic                       h_ok_ff;
   logic                       v_ok_ff;
   logic                       rsp_valid_ff;
   logic [mms_pkg::SUM_W-1:0]  rsp_sum_ff;
   logic [mms_pkg::CODE_W-1:0] rsp_code_ff;

   logic [mms_pkg::SUM_W-1:0]  sum_in;
   logic                       h_ok_in;
   logic                       v_ok_in;
   logic [mms_pkg::CODE_W-1:0] code_in;

   // Fold the current element into the sum and the flags.
   always_comb begin
      sum_in  = (item.restart ? '0 : sum_ff) + mms_pkg::SUM_W'(value);
      h_ok_in = (item.restart || h_ok_ff) && !(item.chk_h && (rd_data_a != value));
      v_ok_in = (item.restart || v_ok_ff) && !(item.chk_v && (rd_data_b != value));
      code_in = (h_ok_in ? mms_pkg::SYM_H0 : mms_pkg::SYM_00)
              | (v_ok_in ? mms_pkg::SYM_0V : mms_pkg::SYM_00);
   end

   // Progress of the matrix in hand.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         sum_ff  <= '0;
         h_ok_ff <= 1'b1;
         v_ok_ff <= 1'b1;
      end else if (item.fire) begin
         if (item.last) begin
            sum_ff  <= '0;
            h_ok_ff <= 1'b1;
            v_ok_ff <= 1'b1;
         end else begin
            sum_ff  <= sum_in;
            h_ok_ff <= h_ok_in;
            v_ok_ff <= v_ok_in;
         end
      end
   end

   // Result valid flag: set by a closing element, cleared when the beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (item.fire && item.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (item.fire && item.last) begin
         rsp_sum_ff  <= sum_in;
         rsp_code_ff <= code_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_sum   = rsp_sum_ff;
   assign rsp_symmetry_code = rsp_code_ff;

   // A closing element presents a result on the next cycle.
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (item.fire && item.last) |=> rsp_valid)
      else $error("mms_acc: closing element produced no result");

   // A closing element never overwrites a result still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !(item.fire && item.last))
      else $error("mms_acc: pending result overwritten");

   // Progress returns to its start after a closing element.
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (item.fire && item.last) |=> (sum_ff == '0 && h_ok_ff && v_ok_ff))
      else $error("mms_acc: progress not cleared after a matrix");

endmodule
